/* hw/rtl/deq_pkg.sv */
// deq_pkg: command and status codes, and the per-cell control bundle
// shared by the deque cell chain and its top level; no dependencies
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_DENIED = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FREE       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IN_LIMITED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OUT_LIMITED = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic list_start;
    logic rotate;
  } cell_ctl_t;

endpackage

/* hw/rtl/deq_cell.sv */
// deq_cell: one queue position of the deque chain, holding an element,
// its valid bit and the tail mark used while listing; uses deq_pkg
`timescale 1ns / 1ps

module deq_cell
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  data_t     value,
  input  data_t     left_data,
  input  logic      left_valid,
  input  data_t     right_data,
  input  logic      right_valid,
  input  logic      right_mark,
  input  data_t     head_data,
  input  logic      head_mark,
  output data_t     data,
  output logic      valid,
  output logic      mark,
  output logic      is_tail
);

  data_t data_next;
  logic  valid_next;
  logic  mark_next;

  assign is_tail = valid && !right_valid;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    mark_next  = mark;
    if (ctl.push_front) begin
      data_next  = left_data;
      valid_next = left_valid;
    end else if (ctl.push_rear) begin
      if (left_valid && !valid) begin
        data_next  = value;
        valid_next = 1'b1;
      end
    end else if (ctl.pop_front) begin
      data_next  = right_data;
      valid_next = right_valid;
    end else if (ctl.pop_rear) begin
      if (is_tail) begin
        valid_next = 1'b0;
      end
    end else if (ctl.list_start) begin
      mark_next = is_tail;
    end else if (ctl.rotate) begin
      // the head element wraps around to the tail
      if (is_tail) begin
        data_next = head_data;
        mark_next = head_mark;
      end else begin
        data_next = right_data;
        mark_next = right_mark;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else begin
      valid <= valid_next;
      mark  <= mark_next;
    end
    data <= data_next;
  end

endmodule

/* hw/rtl/double_ended_queue.sv */
// double_ended_queue: bounded deque built as a chain of deq_cell stages,
// with command decode, mode register and result registers; uses deq_pkg
`timescale 1ns / 1ps
//
// channel   direction  handshake            payload
// command   in         start & !busy        command, value
// config    in         cfg_we               cfg_data
// result    out        strobe (one cycle)   status, element, last
//
// push, pop and rejected commands are carried out when accepted; the result follows on
// the next cycle and a new item may be started right away.
// list walks the chain by rotating it one cell per cycle: busy stays high
// while the stored elements are read out, one result each, the last with last set.
// rst is synchronous and clears the valid bits, tail marks and mode.
// the receiver cannot stall; results are never held.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command,
  input  logic signed [31:0]  value,
  input  logic                cfg_we,
  input  logic [MODE_W-1:0]   cfg_data,
  output logic                strobe,
  output logic [STAT_W-1:0]   status,
  output logic signed [31:0]  element,
  output logic                last
);

  logic [MODE_W-1:0] mode;
  logic              listing;

  data_t      cell_data  [DEPTH];
  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_mark;
  logic [DEPTH-1:0] cell_tail;
  cell_ctl_t  ctl;

  logic  accept;
  logic  denied;
  logic  empty;
  logic  full;
  logic  ok_cmd;
  data_t tail_data;

  assign busy   = listing;
  assign accept = start && !busy;
  assign empty  = !cell_valid[0];
  assign full   = cell_valid[DEPTH-1];

  assign denied = (command > CMD_LIST)
               || (mode == MODE_IN_LIMITED && command == CMD_PUSH_REAR)
               || (mode == MODE_OUT_LIMITED && command == CMD_POP_FRONT);
  assign ok_cmd = accept && !denied;

  always_comb begin
    ctl            = '0;
    ctl.push_front = ok_cmd && command == CMD_PUSH_FRONT && !full;
    ctl.push_rear  = ok_cmd && command == CMD_PUSH_REAR && !full;
    ctl.pop_front  = ok_cmd && command == CMD_POP_FRONT && !empty;
    ctl.pop_rear   = ok_cmd && command == CMD_POP_REAR && !empty;
    ctl.list_start = ok_cmd && command == CMD_LIST && !empty;
    ctl.rotate     = listing;
  end

  // one-hot select of the rear element
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      tail_data = tail_data | (cell_data[i] & {DATA_W{cell_tail[i]}});
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    data_t l_data;
    logic  l_valid;
    data_t r_data;
    logic  r_valid;
    logic  r_mark;

    if (g == 0) begin : g_first
      assign l_data  = value;
      assign l_valid = 1'b1;
    end else begin : g_inner_l
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_final
      assign r_data  = '0;
      assign r_valid = 1'b0;
      assign r_mark  = 1'b0;
    end else begin : g_inner_r
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
      assign r_mark  = cell_mark[g+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .value       (value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .right_mark  (r_mark),
      .head_data   (cell_data[0]),
      .head_mark   (cell_mark[0]),
      .data        (cell_data[g]),
      .valid       (cell_valid[g]),
      .mark        (cell_mark[g]),
      .is_tail     (cell_tail[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_FREE;
      listing <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_data;
      end
      strobe <= 1'b0;
      if (listing) begin
        strobe  <= 1'b1;
        status  <= ST_OK;
        element <= cell_data[0];
        last    <= cell_mark[0];
        if (cell_mark[0]) begin
          listing <= 1'b0;
        end
      end else if (accept) begin
        strobe  <= 1'b1;
        status  <= ST_OK;
        element <= '0;
        last    <= 1'b1;
        if (denied) begin
          status <= ST_DENIED;
        end else begin
          case (command)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              if (full) begin
                status <= ST_FULL;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                element <= cell_data[0];
              end
            end
            CMD_POP_REAR: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                element <= tail_data;
              end
            end
            CMD_LIST: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                strobe  <= 1'b0;
                listing <= 1'b1;
              end
            end
            default: begin
              status <= ST_DENIED;
            end
          endcase
        end
      end
    end
  end

`ifndef SYNTH
  // occupied cells always form a run starting at the head
  assert property (@(posedge clk) disable iff (rst)
    ((cell_valid & (cell_valid + 1'b1)) == '0))
    else $error("valid bits not contiguous");

  // exactly one tail mark travels around the chain while listing
  assert property (@(posedge clk) disable iff (rst)
    listing |-> $onehot(cell_mark))
    else $error("tail mark lost while listing");

  // rotation never changes occupancy
  assert property (@(posedge clk) disable iff (rst)
    listing |=> $stable(cell_valid))
    else $error("occupancy changed during list");

  // a result only follows an accepted item or a list step
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept || listing))
    else $error("result without cause");
`endif

endmodule

/* verif/tb_double_ended_queue.sv */
// tb_double_ended_queue: self-checking testbench for the double-ended queue,
// with a scoreboard class that predicts every result and checks it in order
// depends on deq_pkg and double_ended_queue
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int WATCHDOG = 2000;
  localparam int SETTLE = 4;
  localparam logic [CMD_W-1:0] CMD_MAX = '1;
  localparam logic [MODE_W-1:0] MODE_ALT_FREE = 2'd3;

  typedef struct {
    logic [STAT_W-1:0] status;
    data_t element;
    logic last;
  } deq_result_t;

  class deque_scoreboard;
    data_t ring[QDEPTH];
    int head;
    int fill;
    logic [MODE_W-1:0] mode;
    deq_result_t pending[$];
    int errors;
    int items;
    int results;
    int n_status[4];

    function new();
      head = 0;
      fill = 0;
      mode = MODE_FREE;
      errors = 0;
      items = 0;
      results = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, data_t val);
      deq_result_t r;
      deq_result_t part;
      items++;
      r.status = ST_OK;
      r.element = '0;
      r.last = 1'b1;
      if (cmd > CMD_LIST || (mode == MODE_IN_LIMITED && cmd == CMD_PUSH_REAR) ||
          (mode == MODE_OUT_LIMITED && cmd == CMD_POP_FRONT)) begin
        r.status = ST_DENIED;
      end else begin
        case (cmd)
          CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (fill == QDEPTH) begin
              r.status = ST_FULL;
            end else begin
              if (cmd == CMD_PUSH_FRONT) begin
                head = (head + QDEPTH - 1) % QDEPTH;
                ring[head] = val;
              end else begin
                ring[(head + fill) % QDEPTH] = val;
              end
              fill++;
            end
          end
          CMD_POP_FRONT, CMD_POP_REAR: begin
            if (fill == 0) begin
              r.status = ST_EMPTY;
            end else begin
              if (cmd == CMD_POP_FRONT) begin
                r.element = ring[head];
                head = (head + 1) % QDEPTH;
              end else begin
                r.element = ring[(head + fill - 1) % QDEPTH];
              end
              fill--;
            end
          end
          default: begin
            if (fill == 0) begin
              r.status = ST_EMPTY;
            end else begin
              for (int i = 0; i < fill - 1; i++) begin
                part.status = ST_OK;
                part.element = ring[(head + i) % QDEPTH];
                part.last = 1'b0;
                pending.push_back(part);
                n_status[ST_OK]++;
              end
              r.element = ring[(head + fill - 1) % QDEPTH];
            end
          end
        endcase
      end
      n_status[r.status]++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, data_t el, logic ls);
      deq_result_t e;
      results++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result status %0d element %0d last %0b", st, el, ls));
      end else begin
        e = pending.pop_front();
        if (st !== e.status || el !== e.element || ls !== e.last)
          flag($sformatf("expected status %0d element %0d last %0b, got %0d %0d %0b",
                         e.status, e.element, e.last, st, el, ls));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [CMD_W-1:0] command;
  logic signed [31:0] value;
  logic cfg_we;
  logic [MODE_W-1:0] cfg_data;
  logic strobe;
  logic [STAT_W-1:0] status;
  logic signed [31:0] element;
  logic last;

  deque_scoreboard sb = new();
  int quiet = 0;
  bit filling = 1'b1;
  int run_left = 8;

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .value(value),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .status(status),
    .element(element),
    .last(last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_result(status, element, last);
      if (cfg_we) sb.mode = cfg_data;
      if (start && !busy) sb.note_command(command, value);
      if (strobe || (start && !busy)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, data_t val);
    start <= 1'b1;
    command <= cmd;
    value <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(1, 100) <= pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic data_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'sh8000_0000;
    if (r < 20) return 32'sh7fff_ffff;
    return $urandom;
  endfunction

  // long runs of mostly pushes, then mostly pops, so the ring fills and wraps
  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    bit is_push;
    bit rear;
    if (run_left == 0) begin
      filling = !filling;
      run_left = $urandom_range(4, 20);
    end
    run_left--;
    r = $urandom_range(0, 99);
    if (r < 5) return CMD_W'($urandom_range(CMD_LIST + 1, CMD_MAX));
    if (r < 15) return CMD_LIST;
    is_push = (r < 80) ? filling : !filling;
    rear = $urandom_range(0, 1);
    if (is_push) return rear ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    return rear ? CMD_POP_REAR : CMD_POP_FRONT;
  endfunction

  logic [MODE_W-1:0] phase_mode[4] = '{MODE_IN_LIMITED, MODE_OUT_LIMITED,
                                      MODE_ALT_FREE, MODE_FREE};
  // the receiver never stalls, so only the sender idles
  int phase_idle[4] = '{0, 65, 27, 0};

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    command <= CMD_PUSH_FRONT;
    value <= '0;
    cfg_we <= 1'b0;
    cfg_data <= MODE_FREE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(MODE_FREE);

    // empty queue, field extremes, unknown commands, full ring
    send(CMD_POP_FRONT, 32'sh1234_5678);
    send(CMD_POP_REAR, -1);
    send(CMD_LIST, 0);
    send(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send(CMD_PUSH_REAR, 32'sh8000_0000);
    for (int c = CMD_LIST + 1; c <= CMD_MAX; c++) send(CMD_W'(c), $urandom);
    for (int i = 0; i < QDEPTH - 2; i++)
      send(i[0] ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
    send(CMD_PUSH_FRONT, 0);
    send(CMD_PUSH_REAR, -1);
    send(CMD_LIST, 0);
    send(CMD_POP_FRONT, 0);
    send(CMD_POP_REAR, 0);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_mode(phase_mode[p]);
      send(CMD_PUSH_REAR, pick_value());
      send(CMD_POP_FRONT, pick_value());
      for (int i = 0; i < 18; i++) begin
        if (p == 1 && i == 9) wait_drained();
        maybe_idle(phase_idle[p]);
        send(pick_command(), pick_value());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending.size()));
    $display("covered %0d commands and %0d results in all four modes, with and without gaps",
             sb.items, sb.results);
    $display("status counts: ok %0d, empty %0d, full %0d, denied %0d",
             sb.n_status[ST_OK], sb.n_status[ST_EMPTY], sb.n_status[ST_FULL],
             sb.n_status[ST_DENIED]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
